// ===== hdl/psmp_pkg.sv =====
// Package for the periodic sphere mark-and-probe block.
// Holds the sequencer state type, register indexes, operation codes and reset values.
// Has no dependencies; the top level imports it.
`default_nettype none

package psmp_pkg;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_GG,
		S_HSQ,
		S_AX,
		S_AY,
		S_RUN,
		S_WAIT1,
		S_WAIT2,
		S_DONE
	} state_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_GRID_SIDE    = 2'd0;
	localparam logic [1:0] CFG_HALF_WIDTH   = 2'd1;
	localparam logic [1:0] CFG_RADIUS_LIMIT = 2'd2;

	// Operation codes.
	localparam logic OP_MARK  = 1'b0;
	localparam logic OP_PROBE = 1'b1;

	// Field and register widths.
	localparam int CENTER_W = 6;
	localparam int GSIDE_W  = 7;
	localparam int HWIDTH_W = 4;
	localparam int RADIUS_W = 10;
	localparam int CFG_DATA_W = 10;

	// Register values after reset.
	localparam logic [GSIDE_W-1:0]  GRID_SIDE_RST    = 7'd64;
	localparam logic [HWIDTH_W-1:0] HALF_WIDTH_RST   = 4'd1;
	localparam logic [RADIUS_W-1:0] RADIUS_LIMIT_RST = 10'd2;

endpackage

`default_nettype wire

// ===== hdl/periodic_sphere_mark_and_probe_top.sv =====
// Top level of the periodic sphere mark-and-probe block: sequencer, shared
// multiplier, cell sweep and the one-bit occupancy memory.
// Depends on psmp_pkg.
//
// Usage:
// A transaction is accepted at a rising edge with start high and busy low. It
// names an operation (mark or probe) and a center cell. The block then sweeps
// every offset (l,m,n) of the cube of half width h around the center, one cell
// per cycle, and marks or tests each cell whose squared distance is below
// radius_limit. When done, it raises done for one cycle with hit valid; the
// receiver cannot stall, so the result is simply taken in that cycle.
// Each transaction runs center reduction (a check plus one step per subtraction
// of the grid side), the products g*g, h*h, x base and y base on the shared
// multiplier, the sweep of the (2h+1)^3 cells, then the read drain states
// WAIT1 and WAIT2 and the result state DONE. The maximum half width is 15.
// busy stays high throughout; the next transaction can be
// taken in the idle cycle after done.
// Configuration writes use the cfg channel (cfg_ready always high); write only while idle.
// After reset the memory is cleared by a pass over all GRID_SIDE_MAX^3 cells
// (262144 at the default), with busy high; configuration writes are still taken.
`default_nettype none

module periodic_sphere_mark_and_probe_top #(
	parameter int GRID_SIDE_MAX  = 64,
	parameter int HALF_WIDTH_MAX = 15
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output      logic                             busy,
	input  wire logic                             op,
	input  wire logic [psmp_pkg::CENTER_W-1:0]    center_x,
	input  wire logic [psmp_pkg::CENTER_W-1:0]    center_y,
	input  wire logic [psmp_pkg::CENTER_W-1:0]    center_z,
	output      logic                             done,
	output      logic                             hit,
	input  wire logic                             cfg_valid,
	output      logic                             cfg_ready,
	input  wire logic [1:0]                       cfg_index,
	input  wire logic [psmp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import psmp_pkg::*;

	localparam int CELL_COUNT = GRID_SIDE_MAX * GRID_SIDE_MAX * GRID_SIDE_MAX;
	localparam int AW   = $clog2(CELL_COUNT);
	localparam int GW   = $clog2(GRID_SIDE_MAX + 1);
	localparam int VW   = (GW > CENTER_W) ? GW : CENTER_W;
	localparam int HW   = $clog2(HALF_WIDTH_MAX + 1);
	localparam int SQW  = 2 * HW + 1;
	localparam int DW   = SQW + 2;
	localparam int RW   = (DW > RADIUS_W) ? DW : RADIUS_W;
	localparam int PW   = VW + AW;

	localparam logic signed [HW:0] OFF_STEP = (HW+1)'(1);

	// Configuration registers.
	logic [GSIDE_W-1:0]  grid_side_q;
	logic [HWIDTH_W-1:0] half_width_q;
	logic [RADIUS_W-1:0] radius_q;

	state_t state_q, state_d;

	// Per-transaction registers.
	logic             op_q;
	logic [VW-1:0]    g_q;
	logic [HW-1:0]    h_q;
	logic [VW-1:0]    cx_q, cy_q, cz_q;
	logic [AW-1:0]    gg_q;
	logic [SQW-1:0]   hsq_q;
	logic [VW-1:0]    x_q, y_q, z_q;
	logic [AW-1:0]    ax_q, ay_q, ay0_q;
	logic signed [HW:0] off_l_q, off_m_q, off_n_q;
	logic [SQW-1:0]   sq_l_q, sq_m_q, sq_n_q;
	logic             hit_q;
	logic [AW-1:0]    clr_cnt_q;

	// Memory access pipeline.
	logic             acc_s1;
	logic [AW-1:0]    addr_s1;
	logic             rd_valid_s2;
	logic             rd_data_s2;

	logic mem [CELL_COUNT];

	// Effective grid side and half width from the configuration.
	logic [8:0]    gs_ext;
	logic [VW-1:0] g_eff;
	logic [VW-1:0] hw_ext, h_clamp;
	logic [HW-1:0] h_eff;

	always_comb begin
		gs_ext = 9'(grid_side_q);
		if (gs_ext == 9'd0) begin
			g_eff = VW'(1);
		end else if (gs_ext > 9'(GRID_SIDE_MAX)) begin
			g_eff = VW'(GRID_SIDE_MAX);
		end else begin
			g_eff = VW'(gs_ext);
		end
		hw_ext  = VW'(half_width_q);
		h_clamp = (hw_ext > g_eff) ? g_eff : hw_ext;
		if (h_clamp > VW'(HALF_WIDTH_MAX)) begin
			h_clamp = VW'(HALF_WIDTH_MAX);
		end
		h_eff = HW'(h_clamp);
	end

	// Configuration port, always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q  <= GRID_SIDE_RST;
			half_width_q <= HALF_WIDTH_RST;
			radius_q     <= RADIUS_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GRID_SIDE:    grid_side_q  <= cfg_data[GSIDE_W-1:0];
				CFG_HALF_WIDTH:   half_width_q <= cfg_data[HWIDTH_W-1:0];
				CFG_RADIUS_LIMIT: radius_q     <= cfg_data[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// Shared multiplier, operands chosen by the sequencer state.
	logic [VW-1:0] mul_a;
	logic [AW-1:0] mul_b;
	logic [PW-1:0] mul_p;

	always_comb begin
		case (state_q)
			S_GG: begin
				mul_a = g_q;
				mul_b = AW'(g_q);
			end
			S_HSQ: begin
				mul_a = VW'(h_q);
				mul_b = AW'(h_q);
			end
			S_AX: begin
				mul_a = cx_q;
				mul_b = gg_q;
			end
			S_AY: begin
				mul_a = cy_q;
				mul_b = AW'(g_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = PW'(mul_a) * PW'(mul_b);
	end

	// Center reduction: subtract the grid side until every coordinate is below it.
	logic mod_pending;
	assign mod_pending = (cx_q >= g_q) || (cy_q >= g_q) || (cz_q >= g_q);

	// Sweep bookkeeping.
	logic signed [HW:0] h_s;
	logic               n_last, m_last, l_last;
	logic [DW-1:0]      d2;
	logic [AW-1:0]      addr_cur;
	logic               in_sphere;

	assign h_s      = signed'({1'b0, h_q});
	assign n_last   = (off_n_q == h_s);
	assign m_last   = (off_m_q == h_s);
	assign l_last   = (off_l_q == h_s);
	assign d2       = DW'(sq_l_q) + DW'(sq_m_q) + DW'(sq_n_q);
	assign in_sphere = RW'(d2) < RW'(radius_q);
	assign addr_cur = ax_q + ay_q + AW'(z_q);

	// Square of offset plus one: (o+1)^2 = o^2 + 2o + 1.
	function automatic logic [SQW-1:0] sq_step(input logic [SQW-1:0] sq,
			input logic signed [HW:0] off);
		logic [SQW-1:0] ext;
		ext = SQW'(off);
		return sq + (ext << 1) + SQW'(1);
	endfunction

	// Start coordinate of each axis: (c - h) mod g, with h no larger than g.
	function automatic logic [VW-1:0] wrap_back(input logic [VW-1:0] c,
			input logic [VW-1:0] g, input logic [VW-1:0] h);
		return (c >= h) ? (c - h) : (c + g - h);
	endfunction

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and outputs.
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				if (clr_cnt_q == AW'(CELL_COUNT - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				if (!mod_pending) begin
					state_d = S_GG;
				end
			end
			S_GG:  state_d = S_HSQ;
			S_HSQ: state_d = S_AX;
			S_AX:  state_d = S_AY;
			S_AY:  state_d = S_RUN;
			S_RUN: begin
				if (n_last && m_last && l_last) begin
					state_d = S_WAIT1;
				end
			end
			S_WAIT1: state_d = S_WAIT2;
			S_WAIT2: state_d = S_DONE;
			S_DONE: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign hit = hit_q;

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (state_q == S_CLEAR) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	// Transaction datapath: setup, then one cell per cycle.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q <= op;
					g_q  <= g_eff;
					h_q  <= h_eff;
					cx_q <= VW'(center_x);
					cy_q <= VW'(center_y);
					cz_q <= VW'(center_z);
				end
			end
			S_MOD: begin
				if (cx_q >= g_q) cx_q <= cx_q - g_q;
				if (cy_q >= g_q) cy_q <= cy_q - g_q;
				if (cz_q >= g_q) cz_q <= cz_q - g_q;
			end
			S_GG: begin
				gg_q <= AW'(mul_p);
				cx_q <= wrap_back(cx_q, g_q, VW'(h_q));
				cy_q <= wrap_back(cy_q, g_q, VW'(h_q));
				cz_q <= wrap_back(cz_q, g_q, VW'(h_q));
			end
			S_HSQ: begin
				hsq_q <= SQW'(mul_p);
			end
			S_AX: begin
				ax_q <= AW'(mul_p);
			end
			S_AY: begin
				ay0_q   <= AW'(mul_p);
				ay_q    <= AW'(mul_p);
				x_q     <= cx_q;
				y_q     <= cy_q;
				z_q     <= cz_q;
				off_l_q <= -h_s;
				off_m_q <= -h_s;
				off_n_q <= -h_s;
				sq_l_q  <= hsq_q;
				sq_m_q  <= hsq_q;
				sq_n_q  <= hsq_q;
			end
			S_RUN: begin
				if (!n_last) begin
					off_n_q <= off_n_q + OFF_STEP;
					sq_n_q  <= sq_step(sq_n_q, off_n_q);
					z_q     <= (z_q + VW'(1) == g_q) ? '0 : z_q + VW'(1);
				end else begin
					off_n_q <= -h_s;
					sq_n_q  <= hsq_q;
					z_q     <= cz_q;
					if (!m_last) begin
						off_m_q <= off_m_q + OFF_STEP;
						sq_m_q  <= sq_step(sq_m_q, off_m_q);
						if (y_q + VW'(1) == g_q) begin
							y_q  <= '0;
							ay_q <= '0;
						end else begin
							y_q  <= y_q + VW'(1);
							ay_q <= ay_q + AW'(g_q);
						end
					end else begin
						off_m_q <= -h_s;
						sq_m_q  <= hsq_q;
						y_q     <= cy_q;
						ay_q    <= ay0_q;
						if (!l_last) begin
							off_l_q <= off_l_q + OFF_STEP;
							sq_l_q  <= sq_step(sq_l_q, off_l_q);
							if (x_q + VW'(1) == g_q) begin
								x_q  <= '0;
								ax_q <= '0;
							end else begin
								x_q  <= x_q + VW'(1);
								ax_q <= ax_q + gg_q;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	// Access stage and probe result accumulation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1      <= 1'b0;
			rd_valid_s2 <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			acc_s1      <= (state_q == S_RUN) && in_sphere;
			rd_valid_s2 <= acc_s1 && (op_q == OP_PROBE);
			if (state_q == S_IDLE && start) begin
				hit_q <= 1'b0;
			end else if (rd_valid_s2 && rd_data_s2) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_cur;
	end

	// Occupancy memory: one write port (clear or mark), one registered read port.
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_wdata;

	always_comb begin
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = 1'b0;
		end else begin
			mem_we    = acc_s1 && (op_q == OP_MARK);
			mem_waddr = addr_s1;
			mem_wdata = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s2 <= mem[addr_s1];
	end

endmodule

`default_nettype wire
